### hdl/tcpd_pkg.sv
// ----------------------------------------------------------------------------
// tcpd_pkg: shared types and constants for the two-colour phase dither unit
// Holds field widths, configuration register indexes, the controller state
// type, the controller command and status groups and the result word layout.
// ----------------------------------------------------------------------------
package tcpd_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 16;
    localparam int unsigned MAX_PHASES_DEF      = 4;
    localparam int unsigned OUT_PHASES          = 4;

    localparam int unsigned COLOUR_W   = 8;
    localparam int unsigned RGB_W      = 24;
    localparam int unsigned ENTRY_W    = 4;
    localparam int unsigned FRAC_W     = 9;
    localparam int unsigned DIST_W     = 20;
    localparam int unsigned NPH_W      = 4;
    localparam int unsigned QUO_W      = 8;
    localparam int unsigned NUM_W      = 20;
    localparam int unsigned DEN_W      = 18;
    localparam int unsigned PROD_W     = 13;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned CIU_W      = 5;
    localparam int unsigned PHC_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOURS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 2'd2;

    // input word kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [FRAC_W-1:0] FRAC_FULL = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_PROJ,
        ST_PREP,
        ST_DIVIDE,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       pal_wr;
        logic       load_src;
        logic       rd_en;
        logic       rd_last;
        logic       proj_en;
        logic [1:0] proj_comp;
        logic       div_init;
        logic       div_step;
        logic       scale_en;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic srch_done;
        logic out_free;
    } ctrl_stat_t;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]          pad;
        logic [ENTRY_W-1:0]  phase_three_entry;
        logic [ENTRY_W-1:0]  phase_two_entry;
        logic [ENTRY_W-1:0]  phase_one_entry;
        logic [ENTRY_W-1:0]  phase_zero_entry;
        logic [FRAC_W-1:0]   mix_fraction;
        logic [ENTRY_W-1:0]  second_entry;
        logic [ENTRY_W-1:0]  nearest_entry;
    } result_t;

endpackage

### hdl/tcpd_ram.sv
// ----------------------------------------------------------------------------
// tcpd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcpd_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/tcpd_ctrl.sv
// ----------------------------------------------------------------------------
// tcpd_ctrl: sequencer for the dither lookup unit
// Steps a query through palette search, projection, division and output.
// ----------------------------------------------------------------------------
module tcpd_ctrl import tcpd_pkg::*; #(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int unsigned IDX_W          = $clog2(PALETTE_ENTRIES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_kind,
    input  logic [IDX_W-1:0] ncol_last,
    input  ctrl_stat_t       stat,
    output logic             in_ready,
    output ctrl_cmd_t        cmd,
    output logic [IDX_W-1:0] rd_addr
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [2:0]       step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_kind == KIND_QUERY) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (addr_reg == ncol_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat.srch_done) begin
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ: begin
                if (step_reg == 3'd2) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (step_reg == 3'd7) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and counters
    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        addr_next = addr_reg;
        step_next = step_reg;
        rd_addr   = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready     = 1'b1;
                cmd.pal_wr   = in_valid && in_kind == KIND_WRITE;
                cmd.load_src = in_valid && in_kind == KIND_QUERY;
                addr_next    = '0;
            end
            ST_SEARCH: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = addr_reg == ncol_last;
                addr_next   = addr_reg + 1'b1;
            end
            ST_DRAIN: begin
                step_next = '0;
            end
            ST_PROJ: begin
                cmd.proj_en   = 1'b1;
                cmd.proj_comp = step_reg[1:0];
                step_next     = step_reg + 1'b1;
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
            end
            ST_SCALE: begin
                cmd.scale_en = 1'b1;
            end
            ST_EMIT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/tcpd_dpath.sv
// ----------------------------------------------------------------------------
// tcpd_dpath: datapath of the dither lookup unit
// Palette RAM, distance pipeline, best-two tracker, projection accumulators,
// restoring divider and phase threshold compare.
// ----------------------------------------------------------------------------
module tcpd_dpath import tcpd_pkg::*; #(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int unsigned IDX_W          = $clog2(PALETTE_ENTRIES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [ENTRY_W-1:0]  in_entry,
    input  logic [COLOUR_W-1:0] in_red,
    input  logic [COLOUR_W-1:0] in_green,
    input  logic [COLOUR_W-1:0] in_blue,
    input  logic [NPH_W-1:0]    nph,
    input  logic [DIST_W-1:0]   noise_floor,
    output logic                srch_done,
    output result_t             res
);

    logic                pal_we;
    logic [RGB_W-1:0]    rdata;

    logic [COLOUR_W-1:0] src_r_reg, src_g_reg, src_b_reg;

    logic                r_valid_reg, r_last_reg;
    logic [IDX_W-1:0]    r_idx_reg;

    logic                s1_valid_reg, s1_last_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [RGB_W-1:0]    s1_col_reg;
    logic [COLOUR_W-1:0] s1_dr_reg, s1_dg_reg, s1_db_reg;

    logic                s2_valid_reg, s2_last_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic [RGB_W-1:0]    s2_col_reg;
    logic [15:0]         sq_r_reg, sq_g_reg, sq_b_reg;

    logic                s3_valid_reg, s3_last_reg;
    logic [IDX_W-1:0]    s3_idx_reg;
    logic [RGB_W-1:0]    s3_col_reg;
    logic [DIST_W-1:0]   d_reg;

    logic                v0_reg, v1_reg;
    logic [IDX_W-1:0]    i0_reg, i1_reg;
    logic [DIST_W-1:0]   d0_reg, d1_reg;
    logic [RGB_W-1:0]    c0_reg, c1_reg;
    logic                done_reg;

    logic [COLOUR_W-1:0] pc_src, pc_a, pc_b;
    logic signed [8:0]   ba, ca;
    logic signed [17:0]  term_num, term_den;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]    den_reg;

    logic                num_pos, den_nz, num_ge;
    logic                frac_zero_reg, frac_sat_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W:0]      rem2;
    logic [QUO_W-1:0]    quo_reg;
    logic [FRAC_W-1:0]   frac_comb, frac_reg;

    logic [PROD_W-1:0]   prod;
    logic                dith;
    logic [ENTRY_W-1:0]  near_e, sec_e;
    logic [ENTRY_W-1:0]  ph [OUT_PHASES];

    assign pal_we = cmd.pal_wr && (9'(in_entry) < 9'(PALETTE_ENTRIES));

    tcpd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (IDX_W'(in_entry)),
        .wdata ({in_red, in_green, in_blue}),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // source colour
    always_ff @(posedge aclk) begin
        if (cmd.load_src) begin
            src_r_reg <= in_red;
            src_g_reg <= in_green;
            src_b_reg <= in_blue;
        end
    end

    // distance pipeline valid/last bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            r_valid_reg  <= cmd.rd_en;
            s1_valid_reg <= r_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg && s3_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        r_last_reg  <= cmd.rd_last;
        r_idx_reg   <= rd_addr;

        s1_last_reg <= r_last_reg;
        s1_idx_reg  <= r_idx_reg;
        s1_col_reg  <= rdata;
        s1_dr_reg   <= (src_r_reg > rdata[23:16]) ? src_r_reg - rdata[23:16]
                                                  : rdata[23:16] - src_r_reg;
        s1_dg_reg   <= (src_g_reg > rdata[15:8]) ? src_g_reg - rdata[15:8]
                                                 : rdata[15:8] - src_g_reg;
        s1_db_reg   <= (src_b_reg > rdata[7:0]) ? src_b_reg - rdata[7:0]
                                                : rdata[7:0] - src_b_reg;

        s2_last_reg <= s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_col_reg  <= s1_col_reg;
        sq_r_reg    <= 16'(s1_dr_reg) * 16'(s1_dr_reg);
        sq_g_reg    <= 16'(s1_dg_reg) * 16'(s1_dg_reg);
        sq_b_reg    <= 16'(s1_db_reg) * 16'(s1_db_reg);

        // 2:5:1 weighting
        s3_last_reg <= s2_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_col_reg  <= s2_col_reg;
        d_reg       <= {3'b000, sq_r_reg, 1'b0} + {2'b00, sq_g_reg, 2'b00}
                     + {4'b0000, sq_g_reg} + {4'b0000, sq_b_reg};
    end

    // keep the nearest two, earlier entry wins a tie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (cmd.load_src) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (s3_valid_reg) begin
            if (!v0_reg || d_reg < d0_reg) begin
                v1_reg <= v0_reg;
                v0_reg <= 1'b1;
            end else if (!v1_reg || d_reg < d1_reg) begin
                v1_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg) begin
            if (!v0_reg || d_reg < d0_reg) begin
                i1_reg <= i0_reg;
                d1_reg <= d0_reg;
                c1_reg <= c0_reg;
                i0_reg <= s3_idx_reg;
                d0_reg <= d_reg;
                c0_reg <= s3_col_reg;
            end else if (!v1_reg || d_reg < d1_reg) begin
                i1_reg <= s3_idx_reg;
                d1_reg <= d_reg;
                c1_reg <= s3_col_reg;
            end
        end
    end

    assign srch_done = done_reg;

    // projection, one colour component a cycle
    always_comb begin
        case (cmd.proj_comp)
            2'd0: begin
                pc_src = src_r_reg;
                pc_a   = c0_reg[23:16];
                pc_b   = c1_reg[23:16];
            end
            2'd1: begin
                pc_src = src_g_reg;
                pc_a   = c0_reg[15:8];
                pc_b   = c1_reg[15:8];
            end
            default: begin
                pc_src = src_b_reg;
                pc_a   = c0_reg[7:0];
                pc_b   = c1_reg[7:0];
            end
        endcase
        ba       = $signed({1'b0, pc_b}) - $signed({1'b0, pc_a});
        ca       = $signed({1'b0, pc_src}) - $signed({1'b0, pc_a});
        term_num = ca * ba;
        term_den = ba * ba;
    end

    always_ff @(posedge aclk) begin
        if (cmd.proj_en) begin
            if (cmd.proj_comp == 2'd0) begin
                num_reg <= NUM_W'(term_num);
                den_reg <= DEN_W'($unsigned(term_den));
            end else begin
                num_reg <= num_reg + NUM_W'(term_num);
                den_reg <= den_reg + DEN_W'($unsigned(term_den));
            end
        end
    end

    // restoring divide: num * 256 / den, num below den here
    assign num_pos = !num_reg[NUM_W-1] && (num_reg != '0);
    assign den_nz  = den_reg != '0;
    assign num_ge  = num_reg >= $signed({2'b00, den_reg});
    assign rem2    = {rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            frac_zero_reg <= !(v1_reg && den_nz && num_pos);
            frac_sat_reg  <= v1_reg && den_nz && num_pos && num_ge;
            rem_reg       <= DEN_W'($unsigned(num_reg));
            quo_reg       <= '0;
        end else if (cmd.div_step) begin
            if (rem2 >= {1'b0, den_reg}) begin
                rem_reg <= DEN_W'(rem2 - {1'b0, den_reg});
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem2[DEN_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign frac_comb = frac_zero_reg ? '0 :
                       frac_sat_reg  ? FRAC_FULL : {1'b0, quo_reg};

    always_ff @(posedge aclk) begin
        if (cmd.scale_en) begin
            frac_reg <= frac_comb;
        end
    end

    // frac > (2p+1)*256/(2n)  <=>  frac*n > (2p+1)*128
    assign prod   = PROD_W'(frac_reg) * PROD_W'(nph);
    assign dith   = (nph > NPH_W'(1)) && v1_reg && (d0_reg > noise_floor);
    assign near_e = ENTRY_W'(i0_reg);
    assign sec_e  = v1_reg ? ENTRY_W'(i1_reg) : ENTRY_W'(i0_reg);

    always_comb begin
        for (int p = 0; p < OUT_PHASES; p++) begin
            if (dith && (NPH_W'(p) < nph) && (prod > PROD_W'((2 * p + 1) * 128))) begin
                ph[p] = sec_e;
            end else begin
                ph[p] = near_e;
            end
        end
    end

    always_comb begin
        res                   = '0;
        res.nearest_entry     = near_e;
        res.second_entry      = sec_e;
        res.mix_fraction      = frac_reg;
        res.phase_zero_entry  = ph[0];
        res.phase_one_entry   = ph[1];
        res.phase_two_entry   = ph[2];
        res.phase_three_entry = ph[3];
    end

endmodule

### hdl/two_colour_phase_dither_lut_unit.sv
// ----------------------------------------------------------------------------
// two_colour_phase_dither_lut_unit: phase dither entry builder over a palette
// Loads a palette and, per query colour, returns the nearest two entries,
// the mix fraction between them and the entry for each dither phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis-style ports. s_tuser = 0 writes the colour
//   in s_tdata into palette entry s_tdata[3:0] and gives no result.
//   s_tuser = 1 queries the colour; one result word follows on the m_ ports.
//   A query walks the first N searched palette entries through a single RAM
//   read port, one a cycle, then drains the distance pipeline, runs the
//   projection, a set-up step and the restoring divider (one quotient bit a
//   cycle), then forms the result and loads it. s_tready returns high in the
//   same cycle that m_tvalid rises. The result sits in an output register,
//   so a new word is accepted while the previous result waits; a finished
//   query holds in its last step until that register frees up. A stalled
//   receiver only stalls the next query.
//   Reset (aresetn low, synchronous) sets colours_in_use to 16, phase_count
//   to 4 and noise_floor to 512, and empties the output register. Palette
//   contents are not cleared and must be written before they are searched.
//   The user must write configuration through cfg_wr_en/cfg_index/cfg_wdata only while idle; it is unchecked.
// ----------------------------------------------------------------------------
module two_colour_phase_dither_lut_unit import tcpd_pkg::*; #(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int unsigned MAX_PHASES      = MAX_PHASES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // entry[3:0], red[11:4], green[19:12], blue[27:20], zero [31:28]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // nearest_entry[3:0], second_entry[7:4], mix_fraction[16:8],
    // phase_zero_entry[20:17], phase_one_entry[24:21],
    // phase_two_entry[28:25], phase_three_entry[32:29], zero [39:33]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

    logic [CIU_W-1:0]  colours_in_use_reg;
    logic [PHC_W-1:0]  phase_count_reg;
    logic [DIST_W-1:0] noise_floor_reg;

    logic [8:0]        ncol;
    logic [IDX_W-1:0]  ncol_last;
    logic [NPH_W-1:0]  nph;

    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    logic [IDX_W-1:0]  rd_addr;
    logic              srch_done;
    result_t           res;

    result_t           out_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colours_in_use_reg <= CIU_W'(16);
            phase_count_reg    <= PHC_W'(4);
            noise_floor_reg    <= DIST_W'(512);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLOURS_IN_USE: colours_in_use_reg <= cfg_wdata[CIU_W-1:0];
                REG_PHASE_COUNT:    phase_count_reg    <= cfg_wdata[PHC_W-1:0];
                REG_NOISE_FLOOR:    noise_floor_reg    <= cfg_wdata[DIST_W-1:0];
                default: begin
                    // drop writes outside the register list
                end
            endcase
        end
    end

    // saturate searched entries to 1..PALETTE_ENTRIES
    assign ncol = (colours_in_use_reg == '0) ? 9'd1 :
                  (9'(colours_in_use_reg) > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES) :
                  9'(colours_in_use_reg);
    assign ncol_last = IDX_W'(ncol - 9'd1);

    // saturate phase count to 1..MAX_PHASES
    assign nph = (phase_count_reg == '0) ? NPH_W'(1) :
                 (NPH_W'(phase_count_reg) > NPH_W'(MAX_PHASES)) ? NPH_W'(MAX_PHASES) :
                 NPH_W'(phase_count_reg);

    assign out_free       = !m_tvalid_reg || m_tready;
    assign stat.srch_done = srch_done;
    assign stat.out_free  = out_free;

    tcpd_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .ncol_last (ncol_last),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    tcpd_dpath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .in_entry    (s_tdata[3:0]),
        .in_red      (s_tdata[11:4]),
        .in_green    (s_tdata[19:12]),
        .in_blue     (s_tdata[27:20]),
        .nph         (nph),
        .noise_floor (noise_floor_reg),
        .srch_done   (srch_done),
        .res         (res)
    );

    // output register: load on a finished query, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // never overwrite a word the receiver has not taken
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over a pending word");

    // a query holds off the input until its result is built
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_QUERY) |=> !s_tready)
        else $error("input accepted during a query");

    // mix fraction stays clamped
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:8] <= FRAC_FULL))
        else $error("mix fraction above 256");

    // zero fraction means every phase takes the nearest entry
    a_zero_frac_nearest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16:8] == '0) |->
            (m_tdata[20:17] == m_tdata[3:0] && m_tdata[24:21] == m_tdata[3:0] &&
             m_tdata[28:25] == m_tdata[3:0] && m_tdata[32:29] == m_tdata[3:0]))
        else $error("phase differs from nearest with zero fraction");

endmodule
